// ----- hw/rtl/tbt_pkg.sv -----
// Shared types and constants of the taint balance tracker.
package tbt_pkg;

  localparam int TABLE_ENTRIES = 1024;  // power of two: home slot is the low address bits
  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_USED = 2'd1;
  localparam logic [1:0] ST_GONE = 2'd2;

  localparam logic [1:0] CFG_SEED_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_SEED_AMOUNT_LOW = 2'd1;
  localparam logic [1:0] CFG_SEED_AMOUNT_HIGH = 2'd2;

  typedef enum logic [2:0] {
    RAM_IDLE,
    RAM_READ,
    RAM_CLEAR,
    RAM_SEED,
    RAM_WR_DST,
    RAM_WR_SRC
  } ram_op_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_MOVE,
    EMIT_SAME,
    EMIT_FULL
  } emit_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] block_number;
    logic [15:0] index_in_block;
    logic [63:0] source;
    logic [63:0] destination;
    logic [63:0] value_low;
    logic [63:0] value_high;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_block_number;
    logic [15:0] out_tx_index;
    logic [63:0] out_source;
    logic [63:0] out_destination;
    logic [63:0] moved_low;
    logic [63:0] moved_high;
    logic [63:0] source_left_low;
    logic [63:0] source_left_high;
    logic [63:0] destination_total_low;
    logic [63:0] destination_total_high;
    logic        table_full;
  } out_item_t;

  typedef struct packed {
    logic [1:0]   status;
    logic [63:0]  address;
    logic [127:0] amount;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic    load_item;
    logic    clr_start;
    logic    pos_step;
    logic    probe_start;
    logic    key_dst;
    logic    probe_check;
    logic    latch_src;
    logic    latch_dst;
    logic    compute_take;
    logic    compute_sum;
    ram_op_t ram_op;
    emit_t   emit;
  } cmd_t;

  typedef struct packed {
    logic is_restart;
    logic value_zero;
    logic same_addr;
    logic seed_nonzero;
    logic hit;
    logic free;
    logic last;
    logic ins_avail;
    logic pos_last;
    logic out_busy;
  } sts_t;

endpackage

// ----- hw/rtl/tbt_ram.sv -----
// Generic single-port RAM with registered read.
module tbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/tbt_datapath.sv -----
// Datapath: item, probe pointer, balances, seed registers, table RAM, result register.
module tbt_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  tbt_pkg::cmd_t        cmd,
  output tbt_pkg::sts_t        sts,
  input  tbt_pkg::in_item_t    in_data,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output tbt_pkg::out_item_t   out_data
);

  tbt_pkg::in_item_t item;
  logic [63:0] seed_address, seed_amount_low, seed_amount_high;
  logic [tbt_pkg::IDX_W-1:0] pos, cnt, s_slot, d_slot, ins_slot;
  logic ins_ok, d_found;
  logic [127:0] samt, damt, take, rem, newd;

  logic [tbt_pkg::IDX_W-1:0] ram_addr;
  logic ram_we;
  tbt_pkg::entry_t wword, rword;
  logic [63:0] key;
  logic [127:0] value;

  assign key = cmd.key_dst ? item.destination : item.source;
  assign value = {item.value_high, item.value_low};

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_address <= '0;
      seed_amount_low <= '0;
      seed_amount_high <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tbt_pkg::CFG_SEED_ADDRESS: seed_address <= cfg_data;
        tbt_pkg::CFG_SEED_AMOUNT_LOW: seed_amount_low <= cfg_data;
        tbt_pkg::CFG_SEED_AMOUNT_HIGH: seed_amount_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // probe / sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      cnt <= '0;
    end else if (cmd.clr_start) begin
      pos <= '0;
      cnt <= '0;
    end else if (cmd.probe_start) begin
      pos <= key[tbt_pkg::IDX_W-1:0];
      cnt <= '0;
    end else if (cmd.pos_step) begin
      pos <= (pos == tbt_pkg::IDX_W'(tbt_pkg::TABLE_ENTRIES - 1)) ? '0 : pos + 1'b1;
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ins_ok <= 1'b0;
      d_found <= 1'b0;
    end else if (cmd.probe_start) begin
      ins_ok <= 1'b0;
      d_found <= 1'b0;
    end else begin
      if (cmd.probe_check && !ins_ok && rword.status != tbt_pkg::ST_USED) begin
        ins_ok <= 1'b1;
      end
      if (cmd.latch_dst) begin
        d_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.probe_start) begin
      damt <= '0;
    end
    if (cmd.probe_check && !ins_ok && rword.status != tbt_pkg::ST_USED) begin
      ins_slot <= pos;
    end
    if (cmd.latch_src) begin
      s_slot <= pos;
      samt <= rword.amount;
    end
    if (cmd.latch_dst) begin
      d_slot <= pos;
      damt <= rword.amount;
    end
    if (cmd.compute_take) begin
      take <= (value < samt) ? value : samt;
    end
    if (cmd.compute_sum) begin
      newd <= damt + take;
      rem <= samt - take;
      if (!d_found) begin
        d_slot <= ins_slot;
      end
    end
  end

  // table RAM port
  always_comb begin
    ram_we = 1'b1;
    ram_addr = pos;
    wword = '{status: tbt_pkg::ST_FREE, address: item.destination, amount: newd};
    unique case (cmd.ram_op)
      tbt_pkg::RAM_IDLE: ram_we = 1'b0;
      tbt_pkg::RAM_READ: ram_we = 1'b0;
      tbt_pkg::RAM_CLEAR: ;
      tbt_pkg::RAM_SEED: begin
        ram_addr = seed_address[tbt_pkg::IDX_W-1:0];
        wword = '{status: tbt_pkg::ST_USED, address: seed_address,
                  amount: {seed_amount_high, seed_amount_low}};
      end
      tbt_pkg::RAM_WR_DST: begin
        ram_addr = d_slot;
        wword.status = tbt_pkg::ST_USED;
      end
      tbt_pkg::RAM_WR_SRC: begin
        ram_addr = s_slot;
        wword = '{status: (rem == '0) ? tbt_pkg::ST_GONE : tbt_pkg::ST_USED,
                  address: item.source, amount: rem};
      end
      default: ram_we = 1'b0;
    endcase
  end

  tbt_ram #(
    .WIDTH(tbt_pkg::ENTRY_W),
    .DEPTH(tbt_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk(clk),
    .we(ram_we),
    .addr(ram_addr),
    .wdata(wword),
    .rdata(rword)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != tbt_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != tbt_pkg::EMIT_NONE) begin
      out_data.out_block_number <= item.block_number;
      out_data.out_tx_index <= item.index_in_block;
      out_data.out_source <= item.source;
      out_data.out_destination <= item.destination;
      out_data.table_full <= (cmd.emit == tbt_pkg::EMIT_FULL);
      unique case (cmd.emit)
        tbt_pkg::EMIT_MOVE: begin
          {out_data.moved_high, out_data.moved_low} <= take;
          {out_data.source_left_high, out_data.source_left_low} <= rem;
          {out_data.destination_total_high, out_data.destination_total_low} <= newd;
        end
        tbt_pkg::EMIT_SAME: begin
          {out_data.moved_high, out_data.moved_low} <= take;
          {out_data.source_left_high, out_data.source_left_low} <= samt;
          {out_data.destination_total_high, out_data.destination_total_low} <= samt;
        end
        default: begin
          {out_data.moved_high, out_data.moved_low} <= '0;
          {out_data.source_left_high, out_data.source_left_low} <= samt;
          {out_data.destination_total_high, out_data.destination_total_low} <= '0;
        end
      endcase
    end
  end

  assign sts.is_restart = item.kind;
  assign sts.value_zero = (value == '0);
  assign sts.same_addr = (item.source == item.destination);
  assign sts.seed_nonzero = (seed_amount_low != '0) || (seed_amount_high != '0);
  assign sts.hit = (rword.status == tbt_pkg::ST_USED) && (rword.address == key);
  assign sts.free = (rword.status == tbt_pkg::ST_FREE);
  assign sts.last = (cnt == tbt_pkg::IDX_W'(tbt_pkg::TABLE_ENTRIES - 1));
  assign sts.ins_avail = ins_ok || (rword.status != tbt_pkg::ST_USED);
  assign sts.pos_last = (pos == tbt_pkg::IDX_W'(tbt_pkg::TABLE_ENTRIES - 1));
  assign sts.out_busy = out_valid;

endmodule

// ----- hw/rtl/tbt_ctrl.sv -----
// Controller state machine: sweep, probes, writes and result hand-off.
module tbt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tbt_pkg::sts_t sts,
  output tbt_pkg::cmd_t cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_SEED   = 4'd1;
  localparam logic [3:0] S_IDLE   = 4'd2;
  localparam logic [3:0] S_DECODE = 4'd3;
  localparam logic [3:0] S_SRD    = 4'd4;
  localparam logic [3:0] S_SCHK   = 4'd5;
  localparam logic [3:0] S_TAKE   = 4'd6;
  localparam logic [3:0] S_DRD    = 4'd7;
  localparam logic [3:0] S_DCHK   = 4'd8;
  localparam logic [3:0] S_SUM    = 4'd9;
  localparam logic [3:0] S_WDST   = 4'd10;
  localparam logic [3:0] S_WSRC   = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  logic [3:0] state, state_next;
  logic seed_pending, seed_pending_next;
  tbt_pkg::emit_t mode, mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      seed_pending <= 1'b0;
      mode <= tbt_pkg::EMIT_NONE;
    end else begin
      state <= state_next;
      seed_pending <= seed_pending_next;
      mode <= mode_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    seed_pending_next = seed_pending;
    mode_next = mode;
    cmd = '0;
    cmd.ram_op = tbt_pkg::RAM_IDLE;
    cmd.emit = tbt_pkg::EMIT_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.ram_op = tbt_pkg::RAM_CLEAR;
        cmd.pos_step = 1'b1;
        if (sts.pos_last) begin
          state_next = (seed_pending && sts.seed_nonzero) ? S_SEED : S_IDLE;
          seed_pending_next = 1'b0;
        end
      end
      S_SEED: begin
        cmd.ram_op = tbt_pkg::RAM_SEED;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_restart) begin
          cmd.clr_start = 1'b1;
          seed_pending_next = 1'b1;
          state_next = S_CLEAR;
        end else if (sts.value_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.probe_start = 1'b1;
          state_next = S_SRD;
        end
      end
      S_SRD: begin
        cmd.ram_op = tbt_pkg::RAM_READ;
        state_next = S_SCHK;
      end
      S_SCHK: begin
        cmd.probe_check = 1'b1;
        if (sts.hit) begin
          cmd.latch_src = 1'b1;
          state_next = S_TAKE;
        end else if (sts.free || sts.last) begin
          state_next = S_IDLE;
        end else begin
          cmd.pos_step = 1'b1;
          state_next = S_SRD;
        end
      end
      S_TAKE: begin
        cmd.compute_take = 1'b1;
        if (sts.same_addr) begin
          mode_next = tbt_pkg::EMIT_SAME;
          state_next = S_EMIT;
        end else begin
          cmd.key_dst = 1'b1;
          cmd.probe_start = 1'b1;
          state_next = S_DRD;
        end
      end
      S_DRD: begin
        cmd.key_dst = 1'b1;
        cmd.ram_op = tbt_pkg::RAM_READ;
        state_next = S_DCHK;
      end
      S_DCHK: begin
        cmd.key_dst = 1'b1;
        cmd.probe_check = 1'b1;
        if (sts.hit) begin
          cmd.latch_dst = 1'b1;
          state_next = S_SUM;
        end else if (sts.free || (sts.last && sts.ins_avail)) begin
          state_next = S_SUM;
        end else if (sts.last) begin
          mode_next = tbt_pkg::EMIT_FULL;
          state_next = S_EMIT;
        end else begin
          cmd.pos_step = 1'b1;
          state_next = S_DRD;
        end
      end
      S_SUM: begin
        cmd.compute_sum = 1'b1;
        state_next = S_WDST;
      end
      S_WDST: begin
        cmd.ram_op = tbt_pkg::RAM_WR_DST;
        state_next = S_WSRC;
      end
      S_WSRC: begin
        cmd.ram_op = tbt_pkg::RAM_WR_SRC;
        mode_next = tbt_pkg::EMIT_MOVE;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = mode;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/taint_balance_tracker.sv -----
// Top level of the taint balance tracker.
// Items are handled one at a time. A transfer is accepted and decoded,
// then the source is probed one table slot at a time (linear probe
// from address mod TABLE_ENTRIES over the single-port table RAM), the
// moved amount is picked, the destination is probed slot by slot, and
// the sums are formed, both entries written and the result register loaded.
// A zero-value transfer ends right after decode, an untainted one after its
// source probe. A restart, and reset, run a clearing pass over every table
// slot; a restart then installs the seed if its amount is nonzero. No
// transaction is taken meanwhile, while configuration writes are always
// taken. The result register holds a finished result until the consumer
// takes it; the next result waits in the last step until the register is
// free.
module taint_balance_tracker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tbt_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tbt_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  tbt_pkg::cmd_t cmd;
  tbt_pkg::sts_t sts;

  // config writes are never stalled
  assign cfg_ready = 1'b1;

  tbt_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts(sts),
    .cmd(cmd)
  );

  tbt_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sts(sts),
    .in_data(in_data),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data(out_data)
  );

endmodule

// ----- hw/rtl/tbt_checker.sv -----
// Port-level checker of the taint balance tracker, bound to the top level.
module tbt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tbt_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_ready)
    else $error("ready during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_full_nothing_moved: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.table_full |-> out_data.moved_low == '0 &&
      out_data.moved_high == '0 && out_data.destination_total_low == '0 &&
      out_data.destination_total_high == '0)
    else $error("table full result moved taint");

endmodule

bind taint_balance_tracker tbt_checker u_tbt_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);

// ----- verif/tb_taint_balance_tracker.sv -----
// Self-checking testbench for the taint balance tracker.
module tb_taint_balance_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000; // idle-phase wait + full-table probes + restarts
  localparam int DRAIN_CYCLES   = 4500;  // covers a restart clear or a full-table probe
  localparam int HOLD_CYCLES    = 600;   // long receiver hold-off, fills the block

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  tbt_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tbt_pkg::out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = tbt_pkg::CFG_SEED_ADDRESS;
  logic [63:0] cfg_data = '0;

  taint_balance_tracker dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // transactions waiting to be offered, and reports the block still owes us
  tbt_pkg::in_item_t  transfers_queued[$];
  tbt_pkg::out_item_t taint_reports_due[$];

  // shadow of the seed registers and of the hash table
  logic [63:0]  seed_addr_sh = '0;
  logic [127:0] seed_amt_sh = '0;
  logic [1:0]   slot_status[tbt_pkg::TABLE_ENTRIES];
  logic [63:0]  slot_addr[tbt_pkg::TABLE_ENTRIES];
  logic [127:0] slot_bal[tbt_pkg::TABLE_ENTRIES];

  int  cyc = 0;
  int  errors = 0;
  int  reports_seen = 0;
  int  quiet_cycles = 0;
  logic [63:0] addr_pool[48];

  // linear probe from the home slot; hit = slot holding addr, ins = first reusable slot
  task automatic locate(input logic [63:0] addr, output int hit, output int ins);
    int pos;
    hit = -1;
    ins = -1;
    pos = int'(addr[tbt_pkg::IDX_W-1:0]);
    for (int n = 0; n < tbt_pkg::TABLE_ENTRIES; n++) begin
      if (slot_status[pos] == tbt_pkg::ST_FREE) begin
        if (ins < 0) ins = pos;
        break;
      end
      if (slot_status[pos] == tbt_pkg::ST_USED && slot_addr[pos] == addr) begin
        hit = pos;
        break;
      end
      if (slot_status[pos] == tbt_pkg::ST_GONE && ins < 0) ins = pos;
      pos = (pos + 1) % tbt_pkg::TABLE_ENTRIES;
    end
  endtask

  task automatic wipe_table();
    for (int i = 0; i < tbt_pkg::TABLE_ENTRIES; i++) slot_status[i] = tbt_pkg::ST_FREE;
  endtask

  // predicts the report (if any) caused by one accepted transaction
  task automatic track_transfer(input tbt_pkg::in_item_t it);
    int s, d, ins;
    logic [127:0] val, bal, take, dbal, sum;
    tbt_pkg::out_item_t r;
    if (it.kind) begin
      wipe_table();
      if (seed_amt_sh != '0) begin
        s = int'(seed_addr_sh[tbt_pkg::IDX_W-1:0]);
        slot_status[s] = tbt_pkg::ST_USED;
        slot_addr[s] = seed_addr_sh;
        slot_bal[s] = seed_amt_sh;
      end
      return;
    end
    val = {it.value_high, it.value_low};
    locate(it.source, s, ins);
    if (s < 0 || val == '0) return;
    bal = slot_bal[s];
    take = (val < bal) ? val : bal;
    r = '0;
    r.out_block_number = it.block_number;
    r.out_tx_index = it.index_in_block;
    r.out_source = it.source;
    r.out_destination = it.destination;
    if (it.source == it.destination) begin
      {r.moved_high, r.moved_low} = take;
      {r.source_left_high, r.source_left_low} = bal;
      {r.destination_total_high, r.destination_total_low} = bal;
      taint_reports_due.push_back(r);
      return;
    end
    locate(it.destination, d, ins);
    if (d < 0 && ins < 0) begin
      {r.source_left_high, r.source_left_low} = bal;
      r.table_full = 1'b1;
      taint_reports_due.push_back(r);
      return;
    end
    if (d >= 0) dbal = slot_bal[d];
    else begin
      d = ins;
      dbal = '0;
      slot_status[d] = tbt_pkg::ST_USED;
      slot_addr[d] = it.destination;
    end
    sum = dbal + take;
    slot_bal[d] = sum;
    slot_bal[s] = bal - take;
    if (slot_bal[s] == '0) slot_status[s] = tbt_pkg::ST_GONE;
    {r.moved_high, r.moved_low} = take;
    {r.source_left_high, r.source_left_low} = bal - take;
    {r.destination_total_high, r.destination_total_low} = sum;
    taint_reports_due.push_back(r);
  endtask

  // driver: offers queued transactions, idles at random outside the calm window
  always @(posedge clk) begin
    logic gap;
    cyc <= cyc + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_transfer(in_data);
      if (!in_valid || in_ready) begin
        gap = (cyc >= 20000 && cyc < 26000) ? 1'b0 : ($urandom_range(99) < 12);
        if (transfers_queued.size() > 0 && !gap) begin
          in_data <= transfers_queued.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act);
    if (exp_v !== act) begin
      errors++;
      if (errors <= 10)
        $display("report %0d field %s: expected %h, got %h", reports_seen, name, exp_v, act);
    end
  endtask

  // monitor: random back-pressure plus two long hold-offs, field-wise compare
  always @(posedge clk) begin
    int hold;
    tbt_pkg::out_item_t e;
    if (rst) begin
      out_ready <= 1'b0;
      hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (taint_reports_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected report: %p", out_data);
        end else begin
          e = taint_reports_due.pop_front();
          check_field("out_block_number", 64'(e.out_block_number),
                      64'(out_data.out_block_number));
          check_field("out_tx_index", 64'(e.out_tx_index), 64'(out_data.out_tx_index));
          check_field("out_source", e.out_source, out_data.out_source);
          check_field("out_destination", e.out_destination, out_data.out_destination);
          check_field("moved_low", e.moved_low, out_data.moved_low);
          check_field("moved_high", e.moved_high, out_data.moved_high);
          check_field("source_left_low", e.source_left_low, out_data.source_left_low);
          check_field("source_left_high", e.source_left_high, out_data.source_left_high);
          check_field("destination_total_low", e.destination_total_low,
                      out_data.destination_total_low);
          check_field("destination_total_high", e.destination_total_high,
                      out_data.destination_total_high);
          check_field("table_full", 64'(e.table_full), 64'(out_data.table_full));
        end
        reports_seen++;
        if (reports_seen == 200 || reports_seen == 900) hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (cyc >= 20000 && cyc < 26000) ? 1'b1 : ($urandom_range(99) >= 12);
      end
    end
  end

  // watchdog: cycles without any accepted transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    if (idx == tbt_pkg::CFG_SEED_ADDRESS) seed_addr_sh = value;
    else if (idx == tbt_pkg::CFG_SEED_AMOUNT_LOW) seed_amt_sh[63:0] = value;
    else seed_amt_sh[127:64] = value;
  endtask

  task automatic set_seed(input logic [63:0] addr, input logic [127:0] amt);
    write_reg(tbt_pkg::CFG_SEED_ADDRESS, addr);
    write_reg(tbt_pkg::CFG_SEED_AMOUNT_LOW, amt[63:0]);
    write_reg(tbt_pkg::CFG_SEED_AMOUNT_HIGH, amt[127:64]);
  endtask

  // sender pause: everything accepted, every report back, block given time to settle
  task automatic drain();
    wait (transfers_queued.size() == 0 && !in_valid);
    wait (taint_reports_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send(input logic kind, input logic [63:0] src, input logic [63:0] dst,
                      input logic [127:0] val);
    tbt_pkg::in_item_t it;
    it.kind = kind;
    it.block_number = $urandom;
    it.index_in_block = 16'($urandom);
    it.source = src;
    it.destination = dst;
    {it.value_high, it.value_low} = val;
    transfers_queued.push_back(it);
  endtask

  function automatic logic [127:0] rand_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 20) return {$urandom, $urandom, $urandom, $urandom};
    if (pick < 30) return {64'h0, $urandom, $urandom};
    return {96'h0, 32'($urandom_range(1 << 20, 1))};
  endfunction

  initial begin
    tbt_pkg::in_item_t it;
    wipe_table();
    for (int i = 0; i < 48; i++) begin
      addr_pool[i] = {$urandom, $urandom};
      // a few home slots shared by many addresses to force probing
      if (i % 2 == 0) addr_pool[i][tbt_pkg::IDX_W-1:0] = tbt_pkg::IDX_W'(i % 8);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: the seed holder, deletes, same-address, skipped items
    set_seed(addr_pool[0], {32'h0, 96'hFFFF_FFFF_FFFF_FFFF_FFFF});
    send(1'b1, '0, '0, '0);
    send(1'b0, addr_pool[0], addr_pool[2], '0);                   // zero value
    send(1'b0, addr_pool[5], addr_pool[2], 128'd7);               // untainted source
    send(1'b0, addr_pool[0], addr_pool[0], 128'd9);               // same address
    send(1'b0, addr_pool[0], addr_pool[0], '1);
    send(1'b0, addr_pool[0], addr_pool[2], 128'd1000);
    send(1'b0, addr_pool[0], addr_pool[4], 128'd55);
    send(1'b0, addr_pool[2], addr_pool[4], '1);                   // empties, slot deleted
    send(1'b0, addr_pool[2], addr_pool[6], 128'd1);               // now untainted
    send(1'b0, addr_pool[4], addr_pool[6], 128'd3);               // new destination in a free slot
    send(1'b0, addr_pool[0], addr_pool[8], {64'h1, 64'h0});
    it = '0;
    it.block_number = '1;
    it.index_in_block = '1;
    it.source = addr_pool[0];
    it.destination = '1;
    it.value_low = '1;
    transfers_queued.push_back(it);
    it.block_number = '0;
    it.index_in_block = '0;
    it.destination = '0;
    it.value_low = '0;
    it.value_high = 64'h1;
    transfers_queued.push_back(it);
    drain();

    // extreme seed: all-ones address and amount
    set_seed('1, '1);
    send(1'b1, '1, '1, '1);
    send(1'b0, '1, '0, {64'h8000_0000_0000_0000, 64'h0});
    send(1'b0, '1, 64'h1234, '1);
    send(1'b0, '0, 64'h1234, '1);
    send(1'b0, 64'h1234, '1, 128'd5);
    drain();

    // zero seed leaves the table empty
    set_seed('0, '0);
    send(1'b1, '0, '0, '0);
    send(1'b0, '0, 64'h1, 128'd1);
    drain();

    // fill every slot, then hit the full table
    set_seed('0, {64'h1, 64'h0});
    send(1'b1, '0, '0, '0);
    for (int i = 1; i < tbt_pkg::TABLE_ENTRIES; i++)
      send(1'b0, '0, 64'(i), {96'h0, 32'($urandom_range(1 << 20, 1))});
    for (int i = 0; i < 20; i++) begin
      if (i % 4 == 0)
        send(1'b0, 64'($urandom_range(tbt_pkg::TABLE_ENTRIES - 1)), 64'(5000 + i),
             rand_value());
      else
        send(1'b0, 64'($urandom_range(tbt_pkg::TABLE_ENTRIES - 1)),
             64'($urandom_range(tbt_pkg::TABLE_ENTRIES - 1)), rand_value());
    end
    drain();

    // random traffic over a colliding address pool, occasional restarts and noise
    set_seed(addr_pool[0], {$urandom, $urandom, $urandom, $urandom});
    send(1'b1, '0, '0, '0);
    for (int i = 0; i < 780; i++) begin
      if ($urandom_range(99) < 2)
        send(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, rand_value());
      else if ($urandom_range(99) < 8)
        send(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, rand_value());
      else
        send(1'b0, addr_pool[$urandom_range(47)], addr_pool[$urandom_range(47)],
             rand_value());
    end
    drain();

    // last setting: small seed at address zero
    set_seed('0, 128'd1);
    send(1'b1, '0, '0, '0);
    send(1'b0, '0, 64'h400, '1);
    send(1'b0, 64'h400, '0, 128'd1);
    drain();

    if (errors == 0 && taint_reports_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
